FILE: sv/damped_spring_particle_step_defines.svh
// Assertion shorthands shared by the block's modules.
// Each expects signals named clk and rst_n in the enclosing module.
`ifndef DAMPED_SPRING_PARTICLE_STEP_DEFINES_SVH
`define DAMPED_SPRING_PARTICLE_STEP_DEFINES_SVH

// ante holds -> cons holds in the same cycle
`define DSPS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante holds -> cons holds in the next cycle
`define DSPS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// cond never holds
`define DSPS_ASSERT_NEVER(lbl, cond, msg) \
    `DSPS_ASSERT_IMP(lbl, 1'b1, !(cond), msg)

`endif

FILE: sv/dsps_pkg.sv
`timescale 1ns / 1ps
package dsps_pkg;

    localparam int Q_W   = 32;
    localparam int ACC_W = 49;

    typedef logic signed [Q_W-1:0]   q_t;
    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic signed [47:0]      q48_t;

    localparam q_t Q_MAX = q_t'(32'h7FFF_FFFF);
    localparam q_t Q_MIN = q_t'(32'h8000_0000);

    typedef struct packed {
        logic signed [31:0] load_pos_x;
        logic signed [31:0] load_pos_y;
        logic signed [31:0] load_vel_x;
        logic signed [31:0] load_vel_y;
        logic               load_last;
    } load_item_t;

    typedef struct packed {
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_vel_x;
        logic signed [31:0] out_vel_y;
        logic               out_last;
    } result_item_t;

    typedef enum logic [2:0] {
        REG_STIFFNESS = 3'd0,
        REG_REST_LEN  = 3'd1,
        REG_CUTOFF_SQ = 3'd2,
        REG_DAMPING   = 3'd3,
        REG_TIME_STEP = 3'd4,
        REG_STEPS     = 3'd5
    } reg_index_t;

    // particle word in the kinematics memory
    typedef struct packed {
        q_t pos_x;
        q_t pos_y;
        q_t vel_x;
        q_t vel_y;
    } pv_t;

    // particle word in the force memory
    typedef struct packed {
        q_t fx;
        q_t fy;
    } fv_t;

    typedef struct packed {
        logic [30:0] stiffness;
        logic [30:0] rest_len;
        logic [30:0] cutoff_sq;
    } spring_cfg_t;

    typedef struct packed {
        logic               start;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
    } pair_req_t;

    typedef struct packed {
        logic done;
        logic apply;
        q48_t fx;
        q48_t fy;
    } pair_res_t;

    function automatic q_t sat_q(input acc_t v);
        q_t r;
        if (v[ACC_W-1:Q_W-1] == {(ACC_W-Q_W+1){1'b0}} ||
            v[ACC_W-1:Q_W-1] == {(ACC_W-Q_W+1){1'b1}})
            r = v[Q_W-1:0];
        else if (v[ACC_W-1])
            r = Q_MIN;
        else
            r = Q_MAX;
        return r;
    endfunction

    function automatic q_t sat_add(input q_t a, input q48_t b);
        return sat_q(acc_t'(a) + acc_t'(b));
    endfunction

    function automatic q_t sat_sub(input q_t a, input q48_t b);
        return sat_q(acc_t'(a) - acc_t'(b));
    endfunction

endpackage

FILE: sv/dsps_ram.sv
`timescale 1ns / 1ps
module dsps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/dsps_pair_force.sv
`timescale 1ns / 1ps
`include "damped_spring_particle_step_defines.svh"
module dsps_pair_force
    import dsps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  spring_cfg_t cfg,
    input  pair_req_t   req,
    output pair_res_t   res
);

    typedef enum logic [3:0] {
        PF_IDLE,
        PF_SQUARE,
        PF_SUM,
        PF_ROOT,
        PF_SCALE,
        PF_DIV_SETUP,
        PF_DIV,
        PF_CLAMP,
        PF_FORCE
    } pf_state_t;

    pf_state_t          state_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic [31:0]        ax_reg, ay_reg;
    logic [63:0]        sx_reg, sy_reg;
    logic [63:0]        rad_reg;
    logic [32:0]        rem_reg;
    logic [31:0]        root_reg;
    logic [31:0]        quo_reg;
    logic [4:0]         cnt_reg;
    logic signed [63:0] num_reg;
    logic               neg_reg;
    q_t                 f_reg;
    pair_res_t          res_reg;

    logic [32:0]        ax_c, ay_c;
    logic [64:0]        s_full;
    logic [63:0]        s_sat, limit_c;
    logic               hit_c;
    logic [34:0]        root_sh, root_trial;
    logic               root_ge;
    logic signed [32:0] diff_c;
    logic signed [64:0] num_full;
    logic [63:0]        mag_c;
    logic               div_ovf;
    logic [32:0]        div_sh;
    logic               div_ge;
    logic signed [64:0] fx_full, fy_full;

    always_comb
    begin
        ax_c       = req.dx[32] ? 33'(-req.dx) : 33'(req.dx);
        ay_c       = req.dy[32] ? 33'(-req.dy) : 33'(req.dy);
        s_full     = {1'b0, sx_reg} + {1'b0, sy_reg};
        s_sat      = s_full[64] ? {64{1'b1}} : s_full[63:0];
        limit_c    = {17'd0, cfg.cutoff_sq, 16'd0};
        hit_c      = (s_sat < limit_c) && (s_sat != 64'd0);
        // one result bit of the square root per cycle
        root_sh    = {rem_reg, rad_reg[63:62]};
        root_trial = {1'b0, root_reg, 2'b01};
        root_ge    = root_sh >= root_trial;
        diff_c     = $signed({1'b0, root_reg}) - $signed({2'b00, cfg.rest_len});
        num_full   = $signed({1'b0, cfg.stiffness}) * diff_c;
        mag_c      = num_reg[63] ? 64'(-num_reg) : 64'(num_reg);
        // quotient of 2^32 or more always saturates
        div_ovf    = {1'b0, mag_c[62:32]} >= root_reg;
        div_sh     = {rem_reg[31:0], rad_reg[63]};
        div_ge     = div_sh >= {1'b0, root_reg};
        fx_full    = f_reg * dx_reg;
        fy_full    = f_reg * dy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= PF_IDLE;
            res_reg.done  <= 1'b0;
            res_reg.apply <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            res_reg.done <= 1'b0;
            case (state_reg)
                PF_IDLE:
                begin
                    if (req.start)
                    begin
                        dx_reg    <= req.dx;
                        dy_reg    <= req.dy;
                        ax_reg    <= ax_c[31:0];
                        ay_reg    <= ay_c[31:0];
                        state_reg <= PF_SQUARE;
                    end
                end
                PF_SQUARE:
                begin
                    sx_reg    <= 64'(ax_reg) * 64'(ax_reg);
                    sy_reg    <= 64'(ay_reg) * 64'(ay_reg);
                    state_reg <= PF_SUM;
                end
                PF_SUM:
                begin
                    if (hit_c)
                    begin
                        rad_reg   <= s_sat;
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        cnt_reg   <= '1;
                        state_reg <= PF_ROOT;
                    end
                    else
                    begin
                        res_reg.done  <= 1'b1;
                        res_reg.apply <= 1'b0;
                        state_reg     <= PF_IDLE;
                    end
                end
                PF_ROOT:
                begin
                    rem_reg  <= root_ge ? 33'(root_sh - root_trial) : root_sh[32:0];
                    root_reg <= {root_reg[30:0], root_ge};
                    rad_reg  <= {rad_reg[61:0], 2'b00};
                    cnt_reg  <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0)
                    begin
                        state_reg <= PF_SCALE;
                    end
                end
                PF_SCALE:
                begin
                    num_reg   <= num_full[63:0];
                    state_reg <= PF_DIV_SETUP;
                end
                PF_DIV_SETUP:
                begin
                    neg_reg <= num_reg[63];
                    if (div_ovf)
                    begin
                        f_reg     <= num_reg[63] ? Q_MIN : Q_MAX;
                        state_reg <= PF_FORCE;
                    end
                    else
                    begin
                        rem_reg   <= {2'b00, mag_c[62:32]};
                        rad_reg   <= {mag_c[31:0], 32'd0};
                        quo_reg   <= '0;
                        cnt_reg   <= '1;
                        state_reg <= PF_DIV;
                    end
                end
                PF_DIV:
                begin
                    rem_reg <= div_ge ? 33'(div_sh - {1'b0, root_reg}) : div_sh;
                    quo_reg <= {quo_reg[30:0], div_ge};
                    rad_reg <= {rad_reg[62:0], 1'b0};
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0)
                    begin
                        state_reg <= PF_CLAMP;
                    end
                end
                PF_CLAMP:
                begin
                    if (neg_reg)
                        f_reg <= (quo_reg[31] && quo_reg[30:0] != 31'd0) ? Q_MIN
                                                                        : q_t'(-quo_reg);
                    else
                        f_reg <= quo_reg[31] ? Q_MAX : q_t'(quo_reg);
                    state_reg <= PF_FORCE;
                end
                PF_FORCE:
                begin
                    res_reg.fx    <= fx_full[63:16];
                    res_reg.fy    <= fy_full[63:16];
                    res_reg.done  <= 1'b1;
                    res_reg.apply <= 1'b1;
                    state_reg     <= PF_IDLE;
                end
                default:
                begin
                    state_reg <= PF_IDLE;
                end
            endcase
        end
    end

    assign res = res_reg;

    `DSPS_ASSERT_IMP(a_start_when_idle, req.start, state_reg == PF_IDLE, "pair start while busy")
    `DSPS_ASSERT_NXT(a_done_pulse, res.done, !res.done, "pair done longer than one cycle")
    `DSPS_ASSERT_IMP(a_done_idle, res.done, state_reg == PF_IDLE, "pair done while busy")

endmodule

FILE: sv/damped_spring_particle_step.sv
// Damped spring particle step, 2D, signed Q16.16. Particles load one item
// per cycle into a kinematics memory until an item with load_last; a full
// set (MAX_PARTICLES) ignores further particles, but a load_last item still
// starts the run. The run first zeroes the force memory, one entry per
// particle, then does steps_per_run timesteps. Each timestep walks all
// pairs i < j in order, reading particle i once per row. A pair inside the
// cutoff goes to the shared pair unit, which takes one square-root bit and
// then one quotient bit per cycle (no division when the quotient would
// reach 2^32), then to a read-modify-write of both force entries; a pair
// outside the cutoff or coincident skips both. Damping and semi-implicit
// Euler follow in one pass per particle: a read, then damping, velocity
// and position, each a multiply and an update. Then every particle is sent
// in load order, one at a time, out_last on the final one, and the block
// takes a new set. load_ready is high only while loading. Configuration
// writes are taken at any time and must only come while the block is idle.
`timescale 1ns / 1ps
`include "damped_spring_particle_step_defines.svh"
module damped_spring_particle_step
    import dsps_pkg::*;
#(
    parameter int MAX_PARTICLES = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load_valid,
    output logic         load_ready,
    input  load_item_t   load_item,
    output logic         result_valid,
    input  logic         result_ready,
    output result_item_t result_item,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int IDX_W = $clog2(MAX_PARTICLES);
    localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_PI_RD,
        ST_PI_LD,
        ST_PJ_RD,
        ST_PJ_GO,
        ST_PAIR,
        ST_FI_RD,
        ST_FI_WR,
        ST_FJ_RD,
        ST_FJ_WR,
        ST_NEXT,
        ST_DI_RD,
        ST_DI_LD,
        ST_DAMP_MUL,
        ST_DAMP_SUB,
        ST_VEL_MUL,
        ST_VEL_ADD,
        ST_POS_MUL,
        ST_POS_ADD,
        ST_EM_RD,
        ST_EM_LD,
        ST_EM_WAIT
    } state_t;

    // configuration
    logic [30:0] stiffness_reg;
    logic [30:0] rest_len_reg;
    logic [30:0] cutoff_sq_reg;
    logic [30:0] damping_reg;
    logic [15:0] time_step_reg;
    logic [15:0] steps_reg;

    // sequencer
    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [IDX_W-1:0]   i_reg;
    logic [IDX_W-1:0]   j_reg;
    logic [15:0]        step_reg;
    q_t                 pi_x_reg, pi_y_reg;
    pv_t                cur_reg;
    fv_t                frc_reg;
    logic signed [63:0] prod_x_reg, prod_y_reg;
    result_item_t       result_item_reg;
    logic               result_valid_reg;

    // memories
    logic             a_we, b_we;
    logic [IDX_W-1:0] a_waddr, a_raddr, b_waddr, b_raddr;
    pv_t              a_wdata, a_rdata;
    fv_t              b_wdata, b_rdata;

    // shared multiplier
    q_t                 mul_ax, mul_ay, mul_b;
    logic signed [63:0] mul_x, mul_y;

    pair_req_t   pf_req;
    pair_res_t   pf_res;
    spring_cfg_t pf_cfg;

    logic full_c;
    logic load_acc_c;
    logic more_i_c;
    logic more_j_c;
    logic pairs_c;

    assign full_c     = count_reg == CNT_W'(MAX_PARTICLES);
    assign load_acc_c = load_valid && load_ready;
    assign more_i_c   = (CNT_W'(i_reg) + CNT_W'(1)) < n_reg;
    assign more_j_c   = (CNT_W'(j_reg) + CNT_W'(1)) < n_reg;
    assign pairs_c    = n_reg > CNT_W'(1);

    assign load_ready   = state_reg == ST_LOAD;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result_item  = result_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiffness_reg <= 31'd65536;
            rest_len_reg  <= 31'd65536;
            cutoff_sq_reg <= 31'd262144;
            damping_reg   <= 31'd6554;
            time_step_reg <= 16'd655;
            steps_reg     <= 16'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_STIFFNESS: stiffness_reg <= cfg_data[30:0];
                REG_REST_LEN:  rest_len_reg  <= cfg_data[30:0];
                REG_CUTOFF_SQ: cutoff_sq_reg <= cfg_data[30:0];
                REG_DAMPING:   damping_reg   <= cfg_data[30:0];
                REG_TIME_STEP: time_step_reg <= cfg_data[15:0];
                REG_STEPS:     steps_reg     <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // memory ports follow the state
    always_comb
    begin
        a_we    = 1'b0;
        a_waddr = i_reg;
        a_wdata = cur_reg;
        a_raddr = (state_reg == ST_PJ_RD) ? j_reg : i_reg;
        b_we    = 1'b0;
        b_waddr = i_reg;
        b_wdata = '0;
        b_raddr = (state_reg == ST_FJ_RD) ? j_reg : i_reg;
        case (state_reg)
            ST_LOAD:
            begin
                a_we          = load_acc_c && !full_c;
                a_waddr       = count_reg[IDX_W-1:0];
                a_wdata.pos_x = load_item.load_pos_x;
                a_wdata.pos_y = load_item.load_pos_y;
                a_wdata.vel_x = load_item.load_vel_x;
                a_wdata.vel_y = load_item.load_vel_y;
            end
            ST_CLEAR:
            begin
                b_we = 1'b1;
            end
            ST_FI_WR:
            begin
                b_we       = 1'b1;
                b_wdata.fx = sat_sub(b_rdata.fx, pf_res.fx);
                b_wdata.fy = sat_sub(b_rdata.fy, pf_res.fy);
            end
            ST_FJ_WR:
            begin
                b_we       = 1'b1;
                b_waddr    = j_reg;
                b_wdata.fx = sat_add(b_rdata.fx, pf_res.fx);
                b_wdata.fy = sat_add(b_rdata.fy, pf_res.fy);
            end
            ST_POS_ADD:
            begin
                // new position and velocity back, force cleared for next step
                a_we          = 1'b1;
                a_wdata.pos_x = sat_add(cur_reg.pos_x, prod_x_reg[63:16]);
                a_wdata.pos_y = sat_add(cur_reg.pos_y, prod_y_reg[63:16]);
                b_we          = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // one 32x32 multiplier per axis: alpha*v, then f*dt, then v*dt
    always_comb
    begin
        mul_ax = cur_reg.vel_x;
        mul_ay = cur_reg.vel_y;
        mul_b  = q_t'({16'd0, time_step_reg});
        case (state_reg)
            ST_DAMP_MUL:
            begin
                mul_b = q_t'({1'b0, damping_reg});
            end
            ST_VEL_MUL:
            begin
                mul_ax = frc_reg.fx;
                mul_ay = frc_reg.fy;
            end
            default:
            begin
            end
        endcase
        mul_x = mul_ax * mul_b;
        mul_y = mul_ay * mul_b;
    end

    assign pf_cfg.stiffness = stiffness_reg;
    assign pf_cfg.rest_len  = rest_len_reg;
    assign pf_cfg.cutoff_sq = cutoff_sq_reg;
    assign pf_req.start     = state_reg == ST_PJ_GO;
    assign pf_req.dx        = 33'(pi_x_reg) - 33'(a_rdata.pos_x);
    assign pf_req.dy        = 33'(pi_y_reg) - 33'(a_rdata.pos_y);

    dsps_ram #(
        .WIDTH ($bits(pv_t)),
        .DEPTH (MAX_PARTICLES)
    ) u_kin_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    dsps_ram #(
        .WIDTH ($bits(fv_t)),
        .DEPTH (MAX_PARTICLES)
    ) u_force_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    dsps_pair_force u_pair (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (pf_cfg),
        .req   (pf_req),
        .res   (pf_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            count_reg        <= '0;
            n_reg            <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            step_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_LOAD:
                begin
                    if (load_acc_c)
                    begin
                        if (!full_c)
                            count_reg <= count_reg + CNT_W'(1);
                        if (load_item.load_last)
                        begin
                            n_reg     <= full_c ? count_reg : count_reg + CNT_W'(1);
                            i_reg     <= '0;
                            state_reg <= ST_CLEAR;
                        end
                    end
                end
                ST_CLEAR:
                begin
                    if (more_i_c)
                        i_reg <= i_reg + IDX_W'(1);
                    else
                    begin
                        i_reg    <= '0;
                        step_reg <= '0;
                        if (steps_reg == 16'd0)
                            state_reg <= ST_EM_RD;
                        else if (pairs_c)
                            state_reg <= ST_PI_RD;
                        else
                            state_reg <= ST_DI_RD;
                    end
                end
                ST_PI_RD:
                begin
                    state_reg <= ST_PI_LD;
                end
                ST_PI_LD:
                begin
                    pi_x_reg  <= a_rdata.pos_x;
                    pi_y_reg  <= a_rdata.pos_y;
                    j_reg     <= i_reg + IDX_W'(1);
                    state_reg <= ST_PJ_RD;
                end
                ST_PJ_RD:
                begin
                    state_reg <= ST_PJ_GO;
                end
                ST_PJ_GO:
                begin
                    state_reg <= ST_PAIR;
                end
                ST_PAIR:
                begin
                    if (pf_res.done)
                        state_reg <= pf_res.apply ? ST_FI_RD : ST_NEXT;
                end
                ST_FI_RD:
                begin
                    state_reg <= ST_FI_WR;
                end
                ST_FI_WR:
                begin
                    state_reg <= ST_FJ_RD;
                end
                ST_FJ_RD:
                begin
                    state_reg <= ST_FJ_WR;
                end
                ST_FJ_WR:
                begin
                    state_reg <= ST_NEXT;
                end
                ST_NEXT:
                begin
                    if (more_j_c)
                    begin
                        j_reg     <= j_reg + IDX_W'(1);
                        state_reg <= ST_PJ_RD;
                    end
                    else if ((CNT_W'(i_reg) + CNT_W'(2)) < n_reg)
                    begin
                        i_reg     <= i_reg + IDX_W'(1);
                        state_reg <= ST_PI_RD;
                    end
                    else
                    begin
                        i_reg     <= '0;
                        state_reg <= ST_DI_RD;
                    end
                end
                ST_DI_RD:
                begin
                    state_reg <= ST_DI_LD;
                end
                ST_DI_LD:
                begin
                    cur_reg   <= a_rdata;
                    frc_reg   <= b_rdata;
                    state_reg <= ST_DAMP_MUL;
                end
                ST_DAMP_MUL:
                begin
                    prod_x_reg <= mul_x;
                    prod_y_reg <= mul_y;
                    state_reg  <= ST_DAMP_SUB;
                end
                ST_DAMP_SUB:
                begin
                    frc_reg.fx <= sat_sub(frc_reg.fx, prod_x_reg[63:16]);
                    frc_reg.fy <= sat_sub(frc_reg.fy, prod_y_reg[63:16]);
                    state_reg  <= ST_VEL_MUL;
                end
                ST_VEL_MUL:
                begin
                    prod_x_reg <= mul_x;
                    prod_y_reg <= mul_y;
                    state_reg  <= ST_VEL_ADD;
                end
                ST_VEL_ADD:
                begin
                    cur_reg.vel_x <= sat_add(cur_reg.vel_x, prod_x_reg[63:16]);
                    cur_reg.vel_y <= sat_add(cur_reg.vel_y, prod_y_reg[63:16]);
                    state_reg     <= ST_POS_MUL;
                end
                ST_POS_MUL:
                begin
                    prod_x_reg <= mul_x;
                    prod_y_reg <= mul_y;
                    state_reg  <= ST_POS_ADD;
                end
                ST_POS_ADD:
                begin
                    if (more_i_c)
                    begin
                        i_reg     <= i_reg + IDX_W'(1);
                        state_reg <= ST_DI_RD;
                    end
                    else
                    begin
                        i_reg <= '0;
                        if ((17'(step_reg) + 17'd1) < 17'(steps_reg))
                        begin
                            step_reg  <= step_reg + 16'd1;
                            state_reg <= pairs_c ? ST_PI_RD : ST_DI_RD;
                        end
                        else
                            state_reg <= ST_EM_RD;
                    end
                end
                ST_EM_RD:
                begin
                    state_reg <= ST_EM_LD;
                end
                ST_EM_LD:
                begin
                    result_item_reg.out_pos_x <= a_rdata.pos_x;
                    result_item_reg.out_pos_y <= a_rdata.pos_y;
                    result_item_reg.out_vel_x <= a_rdata.vel_x;
                    result_item_reg.out_vel_y <= a_rdata.vel_y;
                    result_item_reg.out_last  <= !more_i_c;
                    result_valid_reg          <= 1'b1;
                    state_reg                 <= ST_EM_WAIT;
                end
                ST_EM_WAIT:
                begin
                    if (result_ready)
                    begin
                        result_valid_reg <= 1'b0;
                        if (result_item_reg.out_last)
                        begin
                            count_reg <= '0;
                            state_reg <= ST_LOAD;
                        end
                        else
                        begin
                            i_reg     <= i_reg + IDX_W'(1);
                            state_reg <= ST_EM_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    `DSPS_ASSERT_NEVER(a_load_vs_emit, load_ready && result_valid, "loading while emitting")
    `DSPS_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_PARTICLES), "count past depth")
    `DSPS_ASSERT_NXT(a_last_restarts, result_valid && result_ready && result_item.out_last, load_ready && count_reg == '0, "no new set after last item")
    `DSPS_ASSERT_IMP(a_pair_range, pf_req.start, (CNT_W'(i_reg) < CNT_W'(j_reg)) && (CNT_W'(j_reg) < n_reg), "pair index out of range")

endmodule

FILE: tb/damped_spring_particle_step_tb.sv
`timescale 1ns / 1ps
module damped_spring_particle_step_tb;
    import dsps_pkg::*;

    localparam int NPART = 32;
    // index past the register list; writes there must be dropped
    localparam logic [2:0] REG_UNUSED = 3'd6;
    localparam logic signed [31:0] QMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] QMIN = 32'sh8000_0000;
    localparam logic signed [31:0] ONE  = 32'sh0001_0000;

    logic         clk;
    logic         rst_n;
    logic         load_valid;
    logic         load_ready;
    load_item_t   load_item;
    logic         result_valid;
    logic         result_ready;
    result_item_t result_item;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    damped_spring_particle_step #(.MAX_PARTICLES(NPART)) dut (
        .clk(clk), .rst_n(rst_n),
        .load_valid(load_valid), .load_ready(load_ready), .load_item(load_item),
        .result_valid(result_valid), .result_ready(result_ready),
        .result_item(result_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor state: configuration plus particle and force stores.
    // ---------------------------------------------------------------
    logic [30:0] k_stiff, rest_len, cut_sq, alpha;
    logic [15:0] dt, n_steps;
    int px[NPART], py[NPART], vx[NPART], vy[NPART], fx[NPART], fy[NPART];
    int n_held;

    result_item_t pending_particles[$];
    int errors;
    int n_items, n_results, n_sets;
    int send_idle_pct, recv_stall_pct;

    function automatic int sat32(longint v);
        if (v > longint'(QMAX)) return QMAX;
        if (v < longint'(QMIN)) return QMIN;
        return int'(v);
    endfunction

    // Q16.16 product scaling, floor toward minus infinity
    function automatic longint floor16(longint v);
        return v >>> 16;
    endfunction

    function automatic longint unsigned isqrt(longint unsigned x);
        longint unsigned rem, root, b;
        rem = x;
        root = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (rem >= root + b)
            begin
                rem = rem - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    // One timestep: spring forces over all pairs, damping, then Euler.
    function automatic void timestep(int n);
        longint dx, dy, d, f, gx, gy;
        longint unsigned ax, ay, sx, sy, s, lim;
        lim = longint'(cut_sq) << 16;
        for (int i = 0; i < n; i++)
            for (int j = i + 1; j < n; j++)
            begin
                dx = longint'(px[i]) - longint'(px[j]);
                dy = longint'(py[i]) - longint'(py[j]);
                ax = dx < 0 ? -dx : dx;
                ay = dy < 0 ? -dy : dy;
                sx = ax * ax;
                sy = ay * ay;
                s = sx + sy;
                if (s < sx) s = '1;
                if (s >= lim) continue;
                d = longint'(isqrt(s));
                if (d == 0) continue;   // coincident pair: no force
                f = sat32((longint'(k_stiff) * (d - longint'(rest_len))) / d);
                gx = floor16(f * dx);
                gy = floor16(f * dy);
                fx[i] = sat32(longint'(fx[i]) - gx);
                fy[i] = sat32(longint'(fy[i]) - gy);
                fx[j] = sat32(longint'(fx[j]) + gx);
                fy[j] = sat32(longint'(fy[j]) + gy);
            end
        for (int i = 0; i < n; i++)
        begin
            fx[i] = sat32(longint'(fx[i]) - floor16(longint'(alpha) * longint'(vx[i])));
            fy[i] = sat32(longint'(fy[i]) - floor16(longint'(alpha) * longint'(vy[i])));
        end
        for (int i = 0; i < n; i++)
        begin
            vx[i] = sat32(longint'(vx[i]) + floor16(longint'(fx[i]) * longint'(dt)));
            vy[i] = sat32(longint'(vy[i]) + floor16(longint'(fy[i]) * longint'(dt)));
            px[i] = sat32(longint'(px[i]) + floor16(longint'(vx[i]) * longint'(dt)));
            py[i] = sat32(longint'(py[i]) + floor16(longint'(vy[i]) * longint'(dt)));
            fx[i] = 0;
            fy[i] = 0;
        end
    endfunction

    // Accepted particle: store it (unless full); on last, run and queue results.
    function automatic void particle_accepted(load_item_t it);
        result_item_t r;
        if (n_held < NPART)
        begin
            px[n_held] = it.load_pos_x;
            py[n_held] = it.load_pos_y;
            vx[n_held] = it.load_vel_x;
            vy[n_held] = it.load_vel_y;
            n_held++;
        end
        if (!it.load_last) return;
        for (int s = 0; s < int'(n_steps); s++) timestep(n_held);
        for (int i = 0; i < n_held; i++)
        begin
            r.out_pos_x = px[i];
            r.out_pos_y = py[i];
            r.out_vel_x = vx[i];
            r.out_vel_y = vy[i];
            r.out_last  = (i == n_held - 1);
            pending_particles.push_back(r);
        end
        n_sets++;
        n_held = 0;
    endfunction

    function automatic void reg_written(logic [2:0] idx, logic [31:0] d);
        case (idx)
            REG_STIFFNESS: k_stiff  = d[30:0];
            REG_REST_LEN:  rest_len = d[30:0];
            REG_CUTOFF_SQ: cut_sq   = d[30:0];
            REG_DAMPING:   alpha    = d[30:0];
            REG_TIME_STEP: dt       = d[15:0];
            REG_STEPS:     n_steps  = d[15:0];
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    // Valid is only lowered on an idle gap or by stop_sending, so back to
    // back items never see a low and a high assigned in the same step.
    task automatic send_particle(load_item_t it);
        if ($urandom_range(99) < send_idle_pct)
        begin
            load_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        load_valid <= 1'b1;
        load_item  <= it;
        do @(posedge clk); while (!load_ready);
        particle_accepted(it);
        n_items++;
    endtask

    task automatic stop_sending();
        load_valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait until every queued particle is back, then a short settle
    task automatic drain();
        stop_sending();
        while (pending_particles.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        reg_written(idx, d);
    endtask

    // Block is idle whenever this runs. Upper bits beyond each width are
    // set at random to check masking.
    task automatic configure(logic [31:0] k, logic [31:0] d0, logic [31:0] c,
                             logic [31:0] a, logic [31:0] t, logic [31:0] st);
        write_reg(REG_STIFFNESS, {1'($urandom), k[30:0]});
        write_reg(REG_REST_LEN,  {1'($urandom), d0[30:0]});
        write_reg(REG_CUTOFF_SQ, {1'($urandom), c[30:0]});
        write_reg(REG_DAMPING,   {1'($urandom), a[30:0]});
        write_reg(REG_TIME_STEP, {16'($urandom), t[15:0]});
        write_reg(REG_STEPS,     {16'($urandom), st[15:0]});
        write_reg(REG_UNUSED,    $urandom);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic load_item_t particle(int x, int y, int u, int v, bit last);
        load_item_t it;
        it.load_pos_x = x;
        it.load_pos_y = y;
        it.load_vel_x = u;
        it.load_vel_y = v;
        it.load_last  = last;
        return it;
    endfunction

    // mostly small values near the origin so pairs fall inside the cutoff
    function automatic int rand_q();
        case ($urandom_range(9))
            0: return $urandom_range(1) ? QMAX : QMIN;
            1: return $urandom;
            default: return int'($urandom_range(0, 4 * ONE)) - 2 * ONE;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Result checker and receiver stalls
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_particles.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, result_item);
                errors++;
            end
            else
            begin
                result_item_t e;
                e = pending_particles.pop_front();
                if (e.out_pos_x !== result_item.out_pos_x)
                    $display("%0t: pos_x expected %h actual %h", $time,
                             e.out_pos_x, result_item.out_pos_x);
                if (e.out_pos_y !== result_item.out_pos_y)
                    $display("%0t: pos_y expected %h actual %h", $time,
                             e.out_pos_y, result_item.out_pos_y);
                if (e.out_vel_x !== result_item.out_vel_x)
                    $display("%0t: vel_x expected %h actual %h", $time,
                             e.out_vel_x, result_item.out_vel_x);
                if (e.out_vel_y !== result_item.out_vel_y)
                    $display("%0t: vel_y expected %h actual %h", $time,
                             e.out_vel_y, result_item.out_vel_y);
                if (e.out_last !== result_item.out_last)
                    $display("%0t: last expected %b actual %b", $time,
                             e.out_last, result_item.out_last);
                if (e !== result_item) errors++;
                n_results++;
            end
        end
        result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Field extremes, a coincident pair, a pair inside the cutoff, a lone
    // particle, all at reset configuration.
    task automatic test_directed();
        send_particle(particle(QMAX, QMIN, QMAX, QMIN, 1'b0));
        send_particle(particle(QMIN, QMAX, QMIN, QMAX, 1'b1));
        send_particle(particle(ONE, ONE, 0, 0, 1'b0));
        send_particle(particle(ONE, ONE, ONE, -ONE, 1'b1));
        send_particle(particle(0, 0, 0, 0, 1'b0));
        send_particle(particle(ONE / 2, 0, 0, 0, 1'b0));
        send_particle(particle(0, 3 * ONE / 2, -1, 1, 1'b1));
        send_particle(particle(-1, -1, QMAX, QMAX, 1'b1));
        send_particle(particle(0, 0, 0, 0, 1'b0));
        send_particle(particle(32'sh0000_FFFF, 0, 0, 0, 1'b0));
        send_particle(particle(0, -ONE, QMIN, QMIN, 1'b1));
        drain();
    endtask

    // steps_per_run of zero returns particles unchanged
    task automatic test_zero_steps();
        configure(4 * ONE, ONE, 16 * ONE, ONE, 16'hFFFF, 0);
        send_particle(particle(ONE, 0, ONE, 0, 1'b0));
        send_particle(particle(0, ONE / 4, 0, -ONE, 1'b1));
        drain();
    endtask

    // Longest run kept cheap: one particle, no pairs, every step damps.
    task automatic test_long_run();
        configure(0, 0, 0, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_particle(particle(ONE, -ONE, QMAX, QMIN, 1'b1));
        drain();
    endtask

    // Fill the store, then items beyond it are dropped; the last still runs.
    task automatic test_full_store();
        configure(ONE, ONE, 64 * ONE, 6554, 655, 1);
        for (int i = 0; i < NPART + 3; i++)
            send_particle(particle(rand_q(), rand_q(), rand_q(), rand_q(),
                                   i == NPART + 2));
        drain();
    endtask

    // Random sets under the given idling; pauses once mid-phase until all
    // results are back.
    task automatic test_random(int count, int idle, int stall);
        int left, size;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        left = count;
        while (left > 0)
        begin
            size = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
            if (size > left) size = left;
            for (int i = 0; i < size; i++)
                send_particle(particle(rand_q(), rand_q(), rand_q(), rand_q(),
                                       i == size - 1));
            left -= size;
            if (left < count / 2 && left + size >= count / 2) drain();
        end
        drain();
    endtask

    task automatic random_config();
        configure($urandom_range(9) == 0 ? 32'h7FFF_FFFF : $urandom_range(0, 4 * ONE),
                  $urandom_range(0, 2 * ONE),
                  $urandom_range(9) == 0 ? 32'h7FFF_FFFF : $urandom_range(0, 16 * ONE),
                  $urandom_range(0, ONE),
                  $urandom_range(0, 16'hFFFF),
                  $urandom_range(1, 3));
    endtask

    initial
    begin
        rst_n = 1'b0;
        load_valid = 1'b0;
        load_item = '0;
        result_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        n_items = 0;
        n_results = 0;
        n_sets = 0;
        n_held = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        k_stiff = 31'd65536;
        rest_len = 31'd65536;
        cut_sq = 31'd262144;
        alpha = 31'd6554;
        dt = 16'd655;
        n_steps = 16'd1;
        foreach (fx[i])
        begin
            fx[i] = 0;
            fy[i] = 0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_zero_steps();
        test_long_run();
        test_full_store();
        random_config();
        test_random(80, 0, 0);
        // every register but the step count at its top value
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 2);
        test_random(70, 69, 0);
        // zero spring, cutoff, damping and time step
        configure(0, 0, 0, 0, 0, 1);
        test_random(20, 0, 69);
        random_config();
        test_random(60, 0, 69);
        random_config();
        test_random(75, 22, 22);

        $display("Run covered %0d particles in %0d sets, %0d results checked.",
                 n_items, n_sets, n_results);
        $display("Idle and stall phases, register extremes, full store and long run done.");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/dsps_pkg.sv
sv/dsps_ram.sv
sv/dsps_pair_force.sv
sv/damped_spring_particle_step.sv
tb/damped_spring_particle_step_tb.sv
